// File: sv/otm_pkg.sv
// Shared types, constants and tables for the odometry-to-map pose transform.
package otm_pkg;

    localparam int ATAN_LEN = 24;

    localparam logic signed [17:0] TURN_UNITS  = 18'sd11520;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] QUARTER     = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;
    // floor(2^20 / 45) + 1, exact quotient for any r below one turn
    localparam logic [14:0] RECIP_45   = 15'd23302;
    localparam logic [7:0]  DIV_45     = 8'd45;
    // floor(2^24 / 45); remainder term is exact for b < 45
    localparam logic [18:0] FRAC_STEP  = 19'd372827;

    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       ang_init;
        logic       ang_red;
        logic       ang_div;
        logic       ang_z;
        logic       rot;
        logic       trig_set;
        logic       mul;
        logic       acc;
        logic       rnd;
        logic       out_load;
        logic [4:0] step;
        logic [1:0] prod_sel;
        logic       half;
    } otm_cmd_t;

    typedef struct packed {
        logic op;
        logic trig_valid;
        logic red_done;
        logic out_full;
    } otm_stat_t;

    // Product order: dx*cos, dy*sin, dx*sin, dy*cos
    localparam logic [1:0] PROD_XC = 2'd0;
    localparam logic [1:0] PROD_YS = 2'd1;
    localparam logic [1:0] PROD_XS = 2'd2;
    localparam logic [1:0] PROD_YC = 2'd3;

    // Arctangent in binary angle units (2^32 per turn)
    function automatic logic signed [33:0] atan_lookup(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// File: sv/odometry_to_map_pose_transform_unit.sv
// Top level of the odometry-to-map pose transform.
// Each request (tuser = 0: odometry sample, 1: set map pose) yields one map-frame pose.
// One request is in work at a time. A set-pose request goes from capture through the exec
// state straight to the output register. A sample result is built from four 33x34-bit
// products, each done as two passes through one shared 33x18 multiplier plus accumulate
// and round. The first sample after reset or after a set-pose also runs the angle setup
// with its modulo-turn reduction, CORDIC_STEPS CORDIC iterations and a step to latch
// cos/sin, which are then kept until the next set-pose. The output register lets the next
// request be taken while a result waits; a finished request holds until that earlier
// result is taken.
module odometry_to_map_pose_transform_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // pose_x, pose_y, pose_heading, map_number
    input  logic [0:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata   // map_x, map_y, map_heading, current_map
);
    import otm_pkg::*;

    otm_cmd_t  cmd;
    otm_stat_t stat;

    otm_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    otm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser[0]),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: sv/otm_ctrl.sv
// Sequencer for the pose transform: request intake, CORDIC, products, result.
module otm_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  otm_pkg::otm_stat_t  stat,
    output otm_pkg::otm_cmd_t   cmd
);
    import otm_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_EXEC     = 12'b000000000010,
        S_ANG_INIT = 12'b000000000100,
        S_ANG_RED  = 12'b000000001000,
        S_ANG_DIV  = 12'b000000010000,
        S_ANG_Z    = 12'b000000100000,
        S_ROT      = 12'b000001000000,
        S_TRIG     = 12'b000010000000,
        S_MUL      = 12'b000100000000,
        S_ACC      = 12'b001000000000,
        S_RND      = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } otm_state_t;

    otm_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        sel_reg, sel_next;
    logic              half_reg, half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            sel_reg   <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            half_reg  <= half_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        sel_next     = sel_reg;
        half_next    = half_reg;
        cmd          = '0;
        cmd.step     = 5'(step_reg);
        cmd.prod_sel = sel_reg;
        cmd.half     = half_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec  = 1'b1;
                sel_next  = PROD_XC;
                half_next = 1'b0;
                step_next = '0;
                if (stat.op)
                    state_next = S_OUT;
                else if (stat.trig_valid)
                    state_next = S_MUL;
                else
                    state_next = S_ANG_INIT;
            end
            S_ANG_INIT:
            begin
                cmd.ang_init = 1'b1;
                state_next   = S_ANG_RED;
            end
            S_ANG_RED:
            begin
                if (stat.red_done)
                    state_next = S_ANG_DIV;
                else
                    cmd.ang_red = 1'b1;
            end
            S_ANG_DIV:
            begin
                cmd.ang_div = 1'b1;
                state_next  = S_ANG_Z;
            end
            S_ANG_Z:
            begin
                cmd.ang_z  = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = S_TRIG;
                else
                    step_next = step_reg + 1'b1;
            end
            S_TRIG:
            begin
                cmd.trig_set = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (!half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                    state_next = S_RND;
            end
            S_RND:
            begin
                cmd.rnd   = 1'b1;
                half_next = 1'b0;
                if (sel_reg == PROD_YC)
                    state_next = S_OUT;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/otm_dp.sv
// Datapath for the pose transform: pose state, angle setup, CORDIC, multiplier.
module otm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  otm_pkg::otm_cmd_t  cmd,
    output otm_pkg::otm_stat_t stat,
    input  logic               in_op,
    input  logic [87:0]        in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [87:0]        out_data
);
    import otm_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
            return 16'sh7FFF;
        else if (v < -18'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // request registers
    logic              op_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] ph_reg;
    logic [7:0]         mn_reg;

    // pose state
    logic signed [31:0] ref_map_x_reg, ref_map_y_reg, ref_odom_x_reg, ref_odom_y_reg;
    logic signed [31:0] last_odom_x_reg, last_odom_y_reg, cur_x_reg, cur_y_reg;
    logic signed [15:0] ref_map_h_reg, ref_odom_h_reg, last_odom_h_reg, cur_h_reg;
    logic [7:0]         cur_map_reg;

    // rotation setup and CORDIC
    logic signed [17:0] r_reg;
    logic [7:0]         a_reg;
    logic signed [33:0] x_reg, y_reg, z_reg, cos_reg, sin_reg;
    logic               trig_valid_reg;

    // products
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [50:0] prod_reg;
    logic signed [67:0] acc_reg;
    logic signed [39:0] sumx_reg, sumy_reg;

    logic               out_valid_reg;
    logic [87:0]        out_data_reg;

    logic signed [17:0] h_sum, h_wrap;
    logic [28:0]        div_prod;
    logic [13:0]        b_full;
    logic [31:0]        z_u;
    logic signed [33:0] z_x;
    logic signed [33:0] xs, ys, atan_v;
    logic signed [32:0] delta_sel;
    logic signed [33:0] coef_sel;
    logic signed [17:0] coef_part;
    logic signed [67:0] rnd_sum;
    logic signed [37:0] term;
    logic signed [31:0] res_x, res_y;

    always_comb
    begin
        h_sum = 18'(ph_reg) - 18'(ref_odom_h_reg) + 18'(ref_map_h_reg);
        if (h_sum >= TURN_UNITS)
            h_wrap = h_sum - TURN_UNITS;
        else if (h_sum <= -TURN_UNITS)
            h_wrap = h_sum + TURN_UNITS;
        else
            h_wrap = h_sum;
    end

    assign div_prod = 29'(r_reg[13:0]) * 29'(RECIP_45);
    assign b_full   = r_reg[13:0] - 14'(a_reg) * 14'(DIV_45);
    assign z_u      = {a_reg, 24'd0} + 32'(b_full[5:0]) * 32'(FRAC_STEP);
    assign z_x      = 34'($signed(z_u));

    assign xs     = x_reg >>> cmd.step;
    assign ys     = y_reg >>> cmd.step;
    assign atan_v = atan_lookup(cmd.step);

    always_comb
    begin
        delta_sel = (cmd.prod_sel == PROD_XC || cmd.prod_sel == PROD_XS) ? dx_reg : dy_reg;
        coef_sel  = (cmd.prod_sel == PROD_XC || cmd.prod_sel == PROD_YC) ? cos_reg : sin_reg;
        if (cmd.half)
            coef_part = coef_sel[33:16];
        else
            coef_part = $signed({2'b00, coef_sel[15:0]});
    end

    assign rnd_sum = acc_reg + 68'sd536870912;
    assign term    = rnd_sum[67:30];
    assign res_x   = op_reg ? cur_x_reg : sat32(sumx_reg);
    assign res_y   = op_reg ? cur_y_reg : sat32(sumy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_map_x_reg   <= '0;
            ref_map_y_reg   <= '0;
            ref_map_h_reg   <= '0;
            ref_odom_x_reg  <= '0;
            ref_odom_y_reg  <= '0;
            ref_odom_h_reg  <= '0;
            last_odom_x_reg <= '0;
            last_odom_y_reg <= '0;
            last_odom_h_reg <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_h_reg       <= '0;
            cur_map_reg     <= '0;
            trig_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (op_reg)
                begin
                    ref_map_x_reg  <= px_reg;
                    ref_map_y_reg  <= py_reg;
                    ref_map_h_reg  <= ph_reg;
                    ref_odom_x_reg <= last_odom_x_reg;
                    ref_odom_y_reg <= last_odom_y_reg;
                    ref_odom_h_reg <= last_odom_h_reg;
                    trig_valid_reg <= 1'b0;
                    if (cur_map_reg != mn_reg)
                    begin
                        cur_map_reg <= mn_reg;
                        cur_x_reg   <= px_reg;
                        cur_y_reg   <= py_reg;
                        cur_h_reg   <= ph_reg;
                    end
                end
                else
                begin
                    last_odom_x_reg <= px_reg;
                    last_odom_y_reg <= py_reg;
                    last_odom_h_reg <= ph_reg;
                    cur_h_reg       <= sat16(h_wrap);
                end
            end
            if (cmd.trig_set)
                trig_valid_reg <= 1'b1;
            if (cmd.out_load)
            begin
                cur_x_reg <= res_x;
                cur_y_reg <= res_y;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            px_reg <= in_data[31:0];
            py_reg <= in_data[63:32];
            ph_reg <= in_data[79:64];
            mn_reg <= in_data[87:80];
        end
        if (cmd.exec)
        begin
            dx_reg   <= 33'(px_reg) - 33'(ref_odom_x_reg);
            dy_reg   <= 33'(py_reg) - 33'(ref_odom_y_reg);
            sumx_reg <= 40'(ref_map_x_reg);
            sumy_reg <= 40'(ref_map_y_reg);
        end
        if (cmd.ang_init)
            r_reg <= 18'(ref_map_h_reg) - 18'(ref_odom_h_reg);
        if (cmd.ang_red)
        begin
            if (r_reg < 0)
                r_reg <= r_reg + TURN_UNITS;
            else
                r_reg <= r_reg - TURN_UNITS;
        end
        if (cmd.ang_div)
            a_reg <= div_prod[27:20];
        if (cmd.ang_z)
        begin
            y_reg <= '0;
            // fold angles beyond a quarter turn back by a half turn
            if (z_x > QUARTER)
            begin
                x_reg <= -CORDIC_GAIN;
                z_reg <= z_x - HALF_TURN;
            end
            else if (z_x < -QUARTER)
            begin
                x_reg <= -CORDIC_GAIN;
                z_reg <= z_x + HALF_TURN;
            end
            else
            begin
                x_reg <= CORDIC_GAIN;
                z_reg <= z_x;
            end
        end
        if (cmd.rot)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end
        end
        if (cmd.trig_set)
        begin
            cos_reg <= x_reg;
            sin_reg <= y_reg;
        end
        if (cmd.mul)
            prod_reg <= delta_sel * coef_part;
        if (cmd.acc)
        begin
            if (cmd.half)
                acc_reg <= acc_reg + (68'(prod_reg) <<< 16);
            else
                acc_reg <= 68'(prod_reg);
        end
        if (cmd.rnd)
        begin
            unique case (cmd.prod_sel)
                PROD_XC: sumx_reg <= sumx_reg + 40'(term);
                PROD_YS: sumx_reg <= sumx_reg - 40'(term);
                PROD_XS: sumy_reg <= sumy_reg + 40'(term);
                PROD_YC: sumy_reg <= sumy_reg + 40'(term);
                default: sumy_reg <= sumy_reg;
            endcase
        end
        if (cmd.out_load)
            out_data_reg <= {cur_map_reg, cur_h_reg, res_y, res_x};
    end

    assign stat.op         = op_reg;
    assign stat.trig_valid = trig_valid_reg;
    assign stat.red_done   = (r_reg >= 0) && (r_reg < TURN_UNITS);
    assign stat.out_full   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
